/* hdl/olds_pkg.sv */
// Shared types and codes for the ordered list deque with search.
`timescale 1ns / 1ps

package olds_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        CMD_INS_HEAD = 2'd0,
        CMD_INS_TAIL = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_FIND     = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic               accepted;
        logic [COUNT_W-1:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic               ins_head;
        logic               ins_tail;
        logic               remove;
        logic [VALUE_W-1:0] key;
    } ctrl_t;

endpackage

/* hdl/olds_cell.sv */
// One list position: stored value, occupancy bit and match flag.
`timescale 1ns / 1ps

module olds_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  olds_pkg::ctrl_t              ctrl,
    input  logic                         cmp_en,
    input  logic [olds_pkg::VALUE_W-1:0] cmp_key,
    input  logic [olds_pkg::VALUE_W-1:0] left_value,
    input  logic                         left_valid,
    input  logic [olds_pkg::VALUE_W-1:0] right_value,
    input  logic                         right_valid,
    input  logic                         seen_in,
    output logic [olds_pkg::VALUE_W-1:0] value,
    output logic                         valid,
    output logic                         seen_out
);

    logic [olds_pkg::VALUE_W-1:0] value_reg;
    logic [olds_pkg::VALUE_W-1:0] value_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         match_reg;
    logic                         match_next;

    assign value    = value_reg;
    assign valid    = valid_reg;
    assign seen_out = seen_in | match_reg;

    always_comb
    begin
        match_next = match_reg;
        if (cmp_en)
        begin
            match_next = valid_reg && (value_reg == cmp_key);
        end
    end

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.ins_head)
        begin
            value_next = left_value;
            valid_next = left_valid;
        end
        else if (ctrl.ins_tail)
        begin
            if (!valid_reg && left_valid)
            begin
                value_next = ctrl.key;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.remove && seen_out)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* hdl/ordered_list_deque_with_search.sv */
// Ordered list deque with search: top level with the chain of list cells.
// A command is taken into the command registers and the match flag of every cell
// is registered; then, once the result register is free, the first-match flag
// ripples along the chain, the cells shift for an insert or remove and the result
// is registered. A new command is stalled until the current one completes. Reset
// clears the occupancy bits, the count and the handshake state; stored values are not cleared.
`timescale 1ns / 1ps

module ordered_list_deque_with_search #(
    parameter int CAPACITY = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  olds_pkg::in_item_t  cmd_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output olds_pkg::out_item_t rsp_item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                         busy_reg;
    logic                         busy_next;
    logic [1:0]                   cmd_reg;
    logic [1:0]                   cmd_next;
    logic [olds_pkg::VALUE_W-1:0] key_reg;
    logic [olds_pkg::VALUE_W-1:0] key_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    olds_pkg::out_item_t          out_reg;
    olds_pkg::out_item_t          out_next;

    logic                         accept;
    logic                         fire;
    logic                         full;
    logic                         found;
    logic                         is_insert;
    logic                         ins_ok;
    olds_pkg::ctrl_t              ctrl;

    logic [olds_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]          cell_valid;
    logic [CAPACITY:0]            seen;

    assign cmd_stall = busy_reg;
    assign accept    = cmd_valid && !cmd_stall;
    assign fire      = busy_reg && (!out_valid_reg || !rsp_stall);
    assign full      = cell_valid[CAPACITY-1];
    assign found     = seen[CAPACITY];
    assign seen[0]   = 1'b0;
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    assign is_insert = (cmd_reg == olds_pkg::CMD_INS_HEAD) ||
                       (cmd_reg == olds_pkg::CMD_INS_TAIL);
    assign ins_ok    = is_insert && !full;

    always_comb
    begin
        ctrl.ins_head = fire && !full && (cmd_reg == olds_pkg::CMD_INS_HEAD);
        ctrl.ins_tail = fire && !full && (cmd_reg == olds_pkg::CMD_INS_TAIL);
        ctrl.remove   = fire && (cmd_reg == olds_pkg::CMD_REMOVE);
        ctrl.key      = key_reg;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [olds_pkg::VALUE_W-1:0] lv;
            logic                         lval;
            logic [olds_pkg::VALUE_W-1:0] rv;
            logic                         rval;

            if (g == 0)
            begin : g_first
                assign lv   = key_reg;
                assign lval = 1'b1;
            end
            else
            begin : g_mid
                assign lv   = cell_value[g-1];
                assign lval = cell_valid[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign rv   = cell_value[g];
                assign rval = 1'b0;
            end
            else
            begin : g_inner
                assign rv   = cell_value[g+1];
                assign rval = cell_valid[g+1];
            end

            olds_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .cmp_en      (accept),
                .cmp_key     (cmd_item.value),
                .left_value  (lv),
                .left_valid  (lval),
                .right_value (rv),
                .right_valid (rval),
                .seen_in     (seen[g]),
                .value       (cell_value[g]),
                .valid       (cell_valid[g]),
                .seen_out    (seen[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next = 1'b1;
            cmd_next  = cmd_item.cmd;
            key_next  = cmd_item.value;
        end

        if (fire)
        begin
            busy_next = 1'b0;
            if (ins_ok)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if ((cmd_reg == olds_pkg::CMD_REMOVE) && found)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            out_valid_next       = 1'b1;
            out_next.found       = !is_insert && found;
            out_next.accepted    = ins_ok;
            out_next.entry_count = olds_pkg::COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        out_reg <= out_next;
    end

endmodule
